// ----- hdl/pptc_pkg.sv -----
// ---------------------------------------------------------------------------
// pptc_pkg
// shared types and constants for the push/pop trace classifier
// ---------------------------------------------------------------------------
package pptc_pkg;

    localparam int CAPACITY_DEF    = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [2:0] {
        VERD_UNSURE     = 3'd0,
        VERD_IMPOSSIBLE = 3'd1,
        VERD_STACK      = 3'd2,
        VERD_QUEUE      = 3'd3,
        VERD_HEAP       = 3'd4
    } t_verdict;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_RD,
        ST_SQ_CHK,
        ST_HI_RD,
        ST_HI_CHK,
        ST_HP_RD,
        ST_HP_CHK,
        ST_HR_RD,
        ST_HR_CMP,
        ST_HR_RD2,
        ST_HR_CHK,
        ST_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic sq_rd;      // issue stack/fifo top reads
        logic sq_apply;   // apply stack/fifo update
        logic hi_start;   // begin heap insert (or handle drop)
        logic hi_rd;      // read parent
        logic hi_step;    // compare parent, move or finish
        logic hp_rd;      // read heap root
        logic hp_apply;   // compare root, start removal
        logic hr_rd;      // read left child
        logic hr_rd2;     // read right child
        logic hr_step;    // pick child, move or finish
        logic finish;     // emit result
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_pop;
        logic heap_en;     // heap still consistent
        logic hi_go;       // insert needs a sift
        logic hi_more;     // sift-up continues
        logic hr_go;       // removal needs a sift
        logic hr_more;     // sift-down continues
    } t_stat;

    function automatic t_verdict verdict_of(input logic [2:0] f);
        unique case (f)
            3'b000:  verdict_of = VERD_IMPOSSIBLE;
            3'b001:  verdict_of = VERD_STACK;
            3'b010:  verdict_of = VERD_QUEUE;
            3'b100:  verdict_of = VERD_HEAP;
            default: verdict_of = VERD_UNSURE;
        endcase
    endfunction

endpackage

// ----- hdl/pptc_ram.sv -----
// ---------------------------------------------------------------------------
// pptc_ram
// generic single-port-write, single-read ram with registered read
// ---------------------------------------------------------------------------
module pptc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/pptc_ctrl.sv -----
// ---------------------------------------------------------------------------
// pptc_ctrl
// sequencer: stack/fifo step, then heap insert or remove sift loop
// ---------------------------------------------------------------------------
module pptc_ctrl
    import pptc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SQ_RD;
                end
            end
            ST_SQ_RD: begin
                o_cmd.sq_rd = 1'b1;
                n_state     = ST_SQ_CHK;
            end
            ST_SQ_CHK: begin
                o_cmd.sq_apply = 1'b1;
                if (!i_stat.heap_en) begin
                    n_state = ST_DONE;
                end else if (i_stat.is_pop) begin
                    n_state = ST_HP_RD;
                end else begin
                    n_state = ST_HI_RD;
                end
            end
            ST_HI_RD: begin
                o_cmd.hi_start = 1'b1;
                n_state = i_stat.hi_go ? ST_HI_CHK : ST_DONE;
                o_cmd.hi_rd = i_stat.hi_go;
            end
            ST_HI_CHK: begin
                o_cmd.hi_step = 1'b1;
                if (i_stat.hi_more) begin
                    o_cmd.hi_rd = 1'b1;
                    n_state     = ST_HI_CHK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_HP_RD: begin
                o_cmd.hp_rd = 1'b1;
                n_state     = ST_HP_CHK;
            end
            ST_HP_CHK: begin
                o_cmd.hp_apply = 1'b1;
                n_state = i_stat.hr_go ? ST_HR_RD : ST_DONE;
            end
            ST_HR_RD: begin
                o_cmd.hr_rd = 1'b1;
                n_state     = ST_HR_RD2;
            end
            ST_HR_RD2: begin
                o_cmd.hr_rd2 = 1'b1;
                n_state      = ST_HR_CHK;
            end
            ST_HR_CHK: begin
                o_cmd.hr_step = 1'b1;
                n_state = i_stat.hr_more ? ST_HR_RD : ST_DONE;
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ----- hdl/pptc_dp.sv -----
// ---------------------------------------------------------------------------
// pptc_dp
// datapath: three stores, pointers, flags and heap sift registers
// ---------------------------------------------------------------------------
module pptc_dp
    import pptc_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_action,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_last,
    output t_stat                  o_stat,
    output logic                   o_valid,
    output logic [2:0]             o_verdict,
    output logic                   o_overflow,
    output logic                   o_sequence_end
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;  // sift index, room for 2i+2

    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    // captured item (sign bit inverted so unsigned order is signed order)
    logic                   r_pop, r_last;
    logic [VALUE_WIDTH-1:0] r_key;

    logic [CW-1:0] r_scnt, r_fcnt, r_hcnt;
    logic [AW-1:0] r_fhead, r_ftail;
    logic [2:0]    r_flags;
    logic          r_ovf;

    // heap sift state
    logic [IW-1:0]          r_idx;
    logic [VALUE_WIDTH-1:0] r_hkey, r_lval;

    logic                   r_valid;
    logic [2:0]             r_verdict;
    logic                   r_ovf_out, r_end;

    // memory ports
    logic                   s_we, f_we, h_we;
    logic [AW-1:0]          s_wa, s_ra, f_wa, f_ra, h_wa, h_ra;
    logic [VALUE_WIDTH-1:0] h_wd;
    logic [VALUE_WIDTH-1:0] s_rd, f_rd, h_rd;

    pptc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(r_key),
        .i_raddr(s_ra), .o_rdata(s_rd));
    pptc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_fifo (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_wa), .i_wdata(r_key),
        .i_raddr(f_ra), .o_rdata(f_rd));
    pptc_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd));

    logic [IW-1:0] parent, lchild, rchild, hcnt_i;
    logic [CW-1:0] hcnt_dec;
    logic          heap_room;
    logic          hi_move, hr_take_r, hr_move;
    logic [VALUE_WIDTH-1:0] best;
    logic [IW-1:0]          best_i;

    assign hcnt_i    = IW'(r_hcnt);
    assign parent    = (r_idx - IW'(1)) >> 1;
    assign lchild    = {r_idx[IW-2:0], 1'b1};
    assign rchild    = lchild + IW'(1);
    assign hcnt_dec  = r_hcnt - CW'(1);
    assign heap_room = (r_hcnt < CAP_C);
    // the root has no parent, so the key lands there
    assign hi_move   = (r_idx != '0) && (h_rd < r_key);
    assign hr_take_r = (rchild < hcnt_i) && (h_rd > r_lval);
    assign best      = hr_take_r ? h_rd : r_lval;
    assign best_i    = hr_take_r ? rchild : lchild;
    // a node without children keeps the key
    assign hr_move   = (lchild < hcnt_i) && (best > r_hkey);

    // status back to the controller
    always_comb begin
        o_stat          = '0;
        o_stat.is_pop   = r_pop;
        o_stat.heap_en  = r_flags[2];
        o_stat.hi_go    = heap_room && (r_hcnt != '0);
        o_stat.hi_more  = hi_move;
        o_stat.hr_go    = (r_hcnt != '0) && (h_rd == r_key) && (hcnt_dec != '0);
        o_stat.hr_more  = hr_move;
    end

    // memory address and write control
    always_comb begin
        s_we = i_cmd.sq_apply && !r_pop && r_flags[0] && (r_scnt < CAP_C);
        s_wa = AW'(r_scnt);
        s_ra = AW'(r_scnt - CW'(1));
        f_we = i_cmd.sq_apply && !r_pop && r_flags[1] && (r_fcnt < CAP_C);
        f_wa = r_ftail;
        f_ra = r_fhead;
        h_we = 1'b0;
        h_wa = AW'(r_idx);
        h_wd = r_key;
        h_ra = '0;
        if (i_cmd.hi_start) begin
            // place at the end, or read its parent
            h_we = heap_room && (r_hcnt == '0);
            h_wa = '0;
            h_ra = AW'((hcnt_i - IW'(1)) >> 1);
        end else if (i_cmd.hi_step) begin
            h_we = 1'b1;
            h_wa = AW'(r_idx);
            h_wd = hi_move ? h_rd : r_key;
            h_ra = AW'((parent - IW'(1)) >> 1);
        end else if (i_cmd.hp_apply) begin
            h_ra = AW'(hcnt_dec);
        end else if (i_cmd.hr_rd) begin
            h_ra = AW'(lchild);
        end else if (i_cmd.hr_rd2) begin
            h_ra = AW'(rchild);
        end else if (i_cmd.hr_step) begin
            h_we = 1'b1;
            h_wa = AW'(r_idx);
            h_wd = hr_move ? best : r_hkey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scnt  <= '0;
            r_fcnt  <= '0;
            r_hcnt  <= '0;
            r_fhead <= '0;
            r_ftail <= '0;
            r_flags <= 3'b111;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid   <= 1'b0;
            if (i_cmd.load) begin
                r_pop  <= i_action;
                r_last <= i_last;
                r_key  <= {~i_value[VALUE_WIDTH-1], i_value[VALUE_WIDTH-2:0]};
            end
            // stack and fifo step
            if (i_cmd.sq_apply) begin
                if (!r_pop) begin
                    if (r_flags[0]) begin
                        if (r_scnt < CAP_C) r_scnt <= r_scnt + CW'(1);
                        else r_ovf <= 1'b1;
                    end
                    if (r_flags[1]) begin
                        if (r_fcnt < CAP_C) begin
                            r_fcnt  <= r_fcnt + CW'(1);
                            r_ftail <= (r_ftail == LAST_A) ? '0 : r_ftail + AW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end else begin
                    if (r_flags[0]) begin
                        if (r_scnt == '0 || s_rd != r_key) r_flags[0] <= 1'b0;
                        else r_scnt <= r_scnt - CW'(1);
                    end
                    if (r_flags[1]) begin
                        if (r_fcnt == '0 || f_rd != r_key) begin
                            r_flags[1] <= 1'b0;
                        end else begin
                            r_fcnt  <= r_fcnt - CW'(1);
                            r_fhead <= (r_fhead == LAST_A) ? '0 : r_fhead + AW'(1);
                        end
                    end
                end
            end
            // heap insert
            if (i_cmd.hi_start) begin
                if (!heap_room) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_hcnt <= r_hcnt + CW'(1);
                    r_idx  <= hcnt_i;
                end
            end
            if (i_cmd.hi_step && hi_move) begin
                r_idx <= parent;
            end
            // heap pop check
            if (i_cmd.hp_apply) begin
                if (r_hcnt == '0 || h_rd != r_key) begin
                    r_flags[2] <= 1'b0;
                end else begin
                    r_hcnt <= hcnt_dec;
                    r_idx  <= '0;
                end
            end
            if (i_cmd.hr_rd) begin
                // last entry arrives now on first pass
                if (r_idx == '0) begin
                    r_hkey <= h_rd;
                end
            end
            if (i_cmd.hr_rd2) begin
                r_lval <= h_rd;
            end
            if (i_cmd.hr_step) begin
                if (hr_move) r_idx <= best_i;
            end
            // result
            if (i_cmd.finish) begin
                r_valid   <= 1'b1;
                r_verdict <= verdict_of(r_flags);
                r_ovf_out <= r_ovf;
                r_end     <= r_last;
                if (r_last) begin
                    r_scnt  <= '0;
                    r_fcnt  <= '0;
                    r_hcnt  <= '0;
                    r_fhead <= '0;
                    r_ftail <= '0;
                    r_flags <= 3'b111;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_verdict      = r_verdict;
    assign o_overflow     = r_ovf_out;
    assign o_sequence_end = r_end;
endmodule

// ----- hdl/push_pop_trace_classifier_core.sv -----
// ---------------------------------------------------------------------------
// push_pop_trace_classifier_core
// classifies a push/pop trace as stack, queue or priority queue
// ---------------------------------------------------------------------------
// usage:
//   raise start with i_action, i_value, i_last while busy is low; the
//   beat is taken at that edge and busy rises for the item's work.
//   each item gives one result beat: o_valid high for one cycle with
//   o_verdict, o_overflow and o_sequence_end.
//   when the heap shadow is out of play, o_valid follows the states
//   ST_SQ_RD, ST_SQ_CHK and ST_DONE; a heap insert adds ST_HI_RD plus
//   ST_HI_CHK for each parent compare, a heap removal adds ST_HP_RD and
//   ST_HP_CHK plus ST_HR_RD, ST_HR_RD2 and ST_HR_CHK for each level compared
//   on the way down; the sift loop runs over the single heap read port.
//   one item is in work at a time; the next start is taken in the result
//   cycle at the earliest.
//   an item with i_last set closes the sequence: after its result all
//   counters and flags return to their reset values.
//   reset (i_rst_n low, synchronous) empties all three shadows and sets all
//   consistency flags; memory contents are not cleared.
//   the receiver cannot stall; each result beat must be taken when shown.
// ---------------------------------------------------------------------------
module push_pop_trace_classifier_core
    import pptc_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_action,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_last,
    output logic                   o_valid,
    output logic [2:0]             o_verdict,
    output logic                   o_overflow,
    output logic                   o_sequence_end
);
    t_cmd  cmd;
    t_stat stat;

    // sequencer
    pptc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_stat(stat), .o_cmd(cmd), .o_busy(busy));

    // shadows and result register
    pptc_dp #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_action(i_action), .i_value(i_value), .i_last(i_last),
        .o_stat(stat), .o_valid(o_valid), .o_verdict(o_verdict),
        .o_overflow(o_overflow), .o_sequence_end(o_sequence_end));
endmodule
